// ----- rtl/ksd_pkg.sv -----
// Shared types and constants for the Koch segment subdivider.
`timescale 1ns / 1ps

package ksd_pkg;

    // Width of every coordinate field on the channels.
    localparam int FIELD_W = 32;
    // Width of the depth register and of a buffer row index.
    localparam int DEPTH_W = 2;
    // Each refinement step turns one segment into this many points.
    localparam int SEG_SLOTS = 4;
    localparam int SLOT_W = 2;
    // Slot of the segment end point (the fourth point of a refinement).
    localparam logic [SLOT_W-1:0] SLOT_LAST = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ECHO,
        ST_DIFF,
        ST_OFFS,
        ST_STEP,
        ST_NEXT,
        ST_FETCH
    } t_state;

    typedef struct packed {
        logic                 load_vertex;
        logic                 echo;
        logic                 calc_diff;
        logic                 diff_src_ram;
        logic                 calc_off;
        logic                 step_emit;
        logic                 step_write;
        logic [SLOT_W-1:0]    step_sel;
        logic                 last;
        logic                 ram_re;
        logic [DEPTH_W-1:0]   ram_row;
        logic [SLOT_W-1:0]    ram_slot;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

endpackage

// ----- rtl/ksd_if.sv -----
// Channel interfaces for vertex input and point output.
`timescale 1ns / 1ps

interface ksd_vertex_if;
    logic                                valid;
    logic                                ready;
    logic signed [ksd_pkg::FIELD_W-1:0]  vertex_x;
    logic signed [ksd_pkg::FIELD_W-1:0]  vertex_y;
    logic                                start_path;

    modport source (output valid, output vertex_x, output vertex_y, output start_path,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input start_path,
                  output ready);
endinterface

interface ksd_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [ksd_pkg::FIELD_W-1:0]  point_x;
    logic signed [ksd_pkg::FIELD_W-1:0]  point_y;
    logic                                last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// ----- rtl/ksd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ksd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 12
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/ksd_controller.sv -----
// Sequencer that walks the refinement tree depth first and drives the datapath.
`timescale 1ns / 1ps

module ksd_controller #(
    parameter int MAX_DEPTH = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_start,
    output logic                          o_in_ready,
    input  logic                          i_cfg_we,
    input  logic [ksd_pkg::DEPTH_W-1:0]   i_cfg_data,
    input  ksd_pkg::t_dp_sts              i_sts,
    output ksd_pkg::t_dp_cmd              o_cmd
);
    import ksd_pkg::*;

    localparam int LW    = $clog2(MAX_DEPTH + 1);
    localparam int IDX_N = 2 ** LW;

    t_state              r_state, n_state;
    logic                r_have_prev, n_have_prev;
    logic [DEPTH_W-1:0]  r_depth, n_depth;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic [SLOT_W-1:0]   r_k, n_k;
    logic                r_src_ram, n_src_ram;
    logic [SLOT_W-1:0]   r_idx [IDX_N];
    logic [SLOT_W-1:0]   n_idx [IDX_N];

    logic [LW-1:0]       eff_depth;
    logic                accept;
    logic                leaf;
    logic                step_go;
    logic                all_last;
    logic [LW-1:0]       lvl_up;
    logic [LW-1:0]       lvl_dn;

    always_comb begin
        if (int'(r_depth) > MAX_DEPTH) begin
            eff_depth = LW'(MAX_DEPTH);
        end else begin
            eff_depth = LW'(r_depth);
        end
    end

    assign accept  = i_in_valid && (r_state == ST_IDLE);
    assign lvl_up  = LW'(r_lvl + LW'(1));
    assign lvl_dn  = LW'(r_lvl - LW'(1));
    // The children of the segment being refined sit at the level the depth asks for.
    assign leaf    = (lvl_up == eff_depth);
    assign step_go = leaf ? i_sts.out_free : 1'b1;

    // The final point comes from the last child at every open level.
    always_comb begin
        all_last = 1'b1;
        for (int i = 1; i < IDX_N; i++) begin
            if ((i <= int'(r_lvl)) && (r_idx[i] != SLOT_LAST)) begin
                all_last = 1'b0;
            end
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_in_start || !r_have_prev || (eff_depth == '0)) begin
                        n_state = ST_ECHO;
                    end else begin
                        n_state = ST_DIFF;
                    end
                end
            end
            ST_ECHO: begin
                if (i_sts.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIFF:  n_state = ST_OFFS;
            ST_OFFS:  n_state = ST_STEP;
            ST_STEP: begin
                if (step_go && (r_k == SLOT_LAST)) begin
                    n_state = leaf ? ST_NEXT : ST_FETCH;
                end
            end
            ST_NEXT: begin
                if (r_lvl == '0) begin
                    n_state = ST_IDLE;
                end else if (r_idx[r_lvl] != SLOT_LAST) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: n_state = ST_DIFF;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_vertex = accept;
            end
            ST_ECHO: begin
                o_cmd.echo = i_sts.out_free;
            end
            ST_DIFF: begin
                o_cmd.calc_diff    = 1'b1;
                o_cmd.diff_src_ram = r_src_ram;
            end
            ST_OFFS: begin
                o_cmd.calc_off = 1'b1;
            end
            ST_STEP: begin
                o_cmd.step_sel = r_k;
                if (leaf) begin
                    o_cmd.step_emit = i_sts.out_free;
                    o_cmd.last      = (r_k == SLOT_LAST) && all_last;
                end else begin
                    o_cmd.step_write = 1'b1;
                    o_cmd.ram_row    = DEPTH_W'(r_lvl);
                    o_cmd.ram_slot   = r_k;
                end
            end
            ST_FETCH: begin
                o_cmd.ram_re   = 1'b1;
                o_cmd.ram_row  = DEPTH_W'(lvl_dn);
                o_cmd.ram_slot = r_idx[r_lvl];
            end
            ST_NEXT: begin
                o_cmd = '0;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    // Walk counters, path flag and configuration.
    always_comb begin
        n_have_prev = r_have_prev;
        n_depth     = i_cfg_we ? i_cfg_data : r_depth;
        n_lvl       = r_lvl;
        n_k         = r_k;
        n_src_ram   = r_src_ram;
        n_idx       = r_idx;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_lvl     = '0;
                    n_src_ram = 1'b0;
                end
            end
            ST_ECHO: begin
                if (i_sts.out_free) begin
                    n_have_prev = 1'b1;
                end
            end
            ST_OFFS: begin
                n_k = '0;
            end
            ST_STEP: begin
                if (step_go) begin
                    n_k = SLOT_W'(r_k + SLOT_W'(1));
                    if ((r_k == SLOT_LAST) && !leaf) begin
                        n_lvl         = lvl_up;
                        n_idx[lvl_up] = '0;
                    end
                end
            end
            ST_NEXT: begin
                if (r_lvl != '0) begin
                    if (r_idx[r_lvl] != SLOT_LAST) begin
                        n_idx[r_lvl] = SLOT_W'(r_idx[r_lvl] + SLOT_W'(1));
                    end else begin
                        n_lvl = lvl_dn;
                    end
                end
            end
            ST_FETCH: begin
                n_src_ram = 1'b1;
            end
            ST_DIFF: begin
                n_k = r_k;
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_have_prev <= 1'b0;
            r_depth     <= '0;
            r_lvl       <= '0;
            r_k         <= '0;
            r_src_ram   <= 1'b0;
            for (int i = 0; i < IDX_N; i++) begin
                r_idx[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_have_prev <= n_have_prev;
            r_depth     <= n_depth;
            r_lvl       <= n_lvl;
            r_k         <= n_k;
            r_src_ram   <= n_src_ram;
            r_idx       <= n_idx;
        end
    end

endmodule

// ----- rtl/ksd_datapath.sv -----
// Coordinate datapath: vertex and current point, refinement offsets, point buffer, output stage.
`timescale 1ns / 1ps

module ksd_datapath #(
    parameter int MAX_DEPTH   = 3,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ksd_pkg::t_dp_cmd                     i_cmd,
    output ksd_pkg::t_dp_sts                     o_sts,
    input  logic signed [ksd_pkg::FIELD_W-1:0]   i_vertex_x,
    input  logic signed [ksd_pkg::FIELD_W-1:0]   i_vertex_y,
    output logic                                 o_point_valid,
    input  logic                                 i_point_ready,
    output logic signed [ksd_pkg::FIELD_W-1:0]   o_point_x,
    output logic signed [ksd_pkg::FIELD_W-1:0]   o_point_y,
    output logic                                 o_last_point
);
    import ksd_pkg::*;

    localparam int CW        = COORD_WIDTH;
    localparam int DW        = CW + 1;
    localparam int OW        = CW + 3;
    localparam int SW        = CW + 4;
    localparam int RAM_DEPTH = SEG_SLOTS * MAX_DEPTH;
    localparam int AW        = $clog2(RAM_DEPTH);
    localparam longint C_MAX = (longint'(1) <<< (CW - 1)) - longint'(1);
    localparam longint C_MIN = -C_MAX - longint'(1);

    function automatic logic signed [CW-1:0] sat_coord(input longint v);
        logic signed [CW-1:0] r;
        if (v > C_MAX) begin
            r = CW'(C_MAX);
        end else if (v < C_MIN) begin
            r = CW'(C_MIN);
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

    logic signed [CW-1:0] r_vx, r_vy;
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [DW-1:0] r_dx, r_dy;
    logic signed [OW-1:0] r_offx [SEG_SLOTS];
    logic signed [OW-1:0] r_offy [SEG_SLOTS];
    logic signed [CW-1:0] r_ox, r_oy;
    logic                 r_olast;
    logic                 r_ovalid;

    logic signed [CW-1:0] in_x, in_y;
    logic signed [CW-1:0] end_x, end_y;
    logic signed [OW-1:0] dxe, dye;
    logic signed [OW-1:0] off_x [SEG_SLOTS];
    logic signed [OW-1:0] off_y [SEG_SLOTS];
    logic signed [SW-1:0] sum_x, sum_y;
    logic signed [CW-1:0] pt_x, pt_y;
    logic [2*CW-1:0]      ram_rdata;
    logic [AW-1:0]        ram_addr;

    assign in_x = sat_coord(longint'(i_vertex_x));
    assign in_y = sat_coord(longint'(i_vertex_y));

    assign end_x = i_cmd.diff_src_ram ? $signed(ram_rdata[2*CW-1:CW]) : r_vx;
    assign end_y = i_cmd.diff_src_ram ? $signed(ram_rdata[CW-1:0])    : r_vy;

    // Quarter point, peak (half step plus the quarter normal), three-quarter point, end.
    assign dxe = OW'(r_dx);
    assign dye = OW'(r_dy);
    always_comb begin
        off_x[0] = dxe >>> 2;
        off_y[0] = dye >>> 2;
        off_x[1] = (dxe >>> 1) + (dye >>> 2);
        off_y[1] = (dye >>> 1) + ((-dxe) >>> 2);
        off_x[2] = (dxe + (dxe <<< 1)) >>> 2;
        off_y[2] = (dye + (dye <<< 1)) >>> 2;
        off_x[3] = dxe;
        off_y[3] = dye;
    end

    assign sum_x = SW'(r_cx) + SW'(r_offx[i_cmd.step_sel]);
    assign sum_y = SW'(r_cy) + SW'(r_offy[i_cmd.step_sel]);
    assign pt_x  = sat_coord(longint'(sum_x));
    assign pt_y  = sat_coord(longint'(sum_y));

    assign ram_addr = AW'(int'(i_cmd.ram_row) * SEG_SLOTS + int'(i_cmd.ram_slot));

    ksd_ram #(
        .WIDTH (2 * CW),
        .DEPTH (RAM_DEPTH)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (i_cmd.step_write),
        .i_waddr (ram_addr),
        .i_wdata ({pt_x, pt_y}),
        .i_re    (i_cmd.ram_re),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_vertex) begin
            r_vx <= in_x;
            r_vy <= in_y;
        end
        if (i_cmd.calc_diff) begin
            r_dx <= DW'(end_x) - DW'(r_cx);
            r_dy <= DW'(end_y) - DW'(r_cy);
        end
        if (i_cmd.calc_off) begin
            for (int i = 0; i < SEG_SLOTS; i++) begin
                r_offx[i] <= off_x[i];
                r_offy[i] <= off_y[i];
            end
        end
        if (i_cmd.echo) begin
            r_ox    <= r_vx;
            r_oy    <= r_vy;
            r_olast <= 1'b1;
        end else if (i_cmd.step_emit) begin
            r_ox    <= pt_x;
            r_oy    <= pt_y;
            r_olast <= i_cmd.last;
        end
    end

    // The current point is the last segment end emitted, and so the stored vertex between items.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.echo) begin
                r_cx <= r_vx;
                r_cy <= r_vy;
            end else if (i_cmd.step_emit && (i_cmd.step_sel == SLOT_LAST)) begin
                r_cx <= pt_x;
                r_cy <= pt_y;
            end
            if (i_cmd.echo || i_cmd.step_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_point_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_ovalid || i_point_ready;
    assign o_point_valid  = r_ovalid;
    assign o_point_x      = FIELD_W'(r_ox);
    assign o_point_y      = FIELD_W'(r_oy);
    assign o_last_point   = r_olast;

endmodule

// ----- rtl/koch_segment_subdivider.sv -----
// Top level of the Koch segment subdivider: controller, datapath and their channels.
`timescale 1ns / 1ps

// Channel     Dir  Payload                              Transfer when
// i_vertex    in   vertex_x, vertex_y, start_path       valid && ready
// o_point     out  point_x, point_y, last_point         valid && ready
// i_cfg_*     in   subdivision_depth (2 bits)           i_cfg_we
//
// A path start (or a vertex with no stored predecessor, or depth zero)
// yields one point. The single shared refinement unit refines each segment
// in ST_DIFF, ST_OFFS and ST_STEP, plus a fetch and a step of the walk per
// visited child. Reset is synchronous and active low; it marks the stored
// vertex invalid and clears the depth and the output stage. A stall on
// o_point freezes the walk only while a point is waiting to leave; a new
// vertex is taken right after an echo, or once ST_NEXT has unwound every
// open level after the last point of a segment has been issued.

module koch_segment_subdivider #(
    parameter int MAX_DEPTH   = 3,
    parameter int COORD_WIDTH = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    ksd_vertex_if.sink                   i_vertex,
    ksd_point_if.source                  o_point,
    input  logic                         i_cfg_we,
    input  logic [ksd_pkg::DEPTH_W-1:0]  i_cfg_data
);
    import ksd_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    // The controller owns the input handshake and the depth register; the
    // datapath owns every coordinate and the output register.
    ksd_controller #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vertex.valid),
        .i_in_start (i_vertex.start_path),
        .o_in_ready (in_ready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    ksd_datapath #(
        .MAX_DEPTH   (MAX_DEPTH),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_vertex_x    (i_vertex.vertex_x),
        .i_vertex_y    (i_vertex.vertex_y),
        .o_point_valid (o_point.valid),
        .i_point_ready (o_point.ready),
        .o_point_x     (o_point.point_x),
        .o_point_y     (o_point.point_y),
        .o_last_point  (o_point.last_point)
    );

    assign i_vertex.ready = in_ready;

endmodule

// ----- rtl/ksd_checker.sv -----
// Port-level assertions for the Koch segment subdivider and their binding.
`timescale 1ns / 1ps

module ksd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [ksd_pkg::FIELD_W-1:0]  i_out_x,
    input logic signed [ksd_pkg::FIELD_W-1:0]  i_out_y,
    input logic                                i_out_last
);

    // A held point must not change until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_x)
            && $stable(i_out_y) && $stable(i_out_last)))
        else $error("output point changed or dropped while stalled");

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // One vertex is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken again right after a transfer");

    // A waiting point that is not the last of its vertex means work is still open.
    a_busy_mid_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_last) |-> !i_in_ready)
        else $error("input ready before the last point of a vertex");

endmodule

bind koch_segment_subdivider ksd_checker u_ksd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_vertex.valid),
    .i_in_ready  (i_vertex.ready),
    .i_out_valid (o_point.valid),
    .i_out_ready (o_point.ready),
    .i_out_x     (o_point.point_x),
    .i_out_y     (o_point.point_y),
    .i_out_last  (o_point.last_point)
);

// ----- dv/koch_segment_subdivider_tb.sv -----
// Self-checking testbench for the Koch segment subdivider with an in-bench point predictor.
`timescale 1ns / 1ps

module koch_segment_subdivider_tb;
    import ksd_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int COORD_MAX  = 32'sh7fff_ffff;
    localparam int COORD_MIN  = 32'sh8000_0000;
    localparam int REPORT_MAX = 10;
    // The slowest item is a depth-three segment: its refinement work plus
    // 64 points, each of which can sit behind a long receiver stall. Around 300
    // such items fit well within this bound.
    localparam int unsigned CYCLE_LIMIT = 2_000_000;
    // Quiet cycles after the last point, longer than one depth-three segment.
    localparam int TAIL_CYCLES = 400;

    typedef struct {
        int x;
        int y;
        bit last;
    } t_koch_point;

    typedef struct {
        int x;
        int y;
        bit start;
    } t_vertex_item;

    // Tracks the stored vertex and depth, expands every accepted vertex into
    // the points it must produce, and checks the point stream against them.
    class koch_tracker;
        t_koch_point points_due[$];
        int prev_x;
        int prev_y;
        bit have_prev;
        int unsigned depth;
        int fails;

        function new();
            prev_x = 0;
            prev_y = 0;
            have_prev = 1'b0;
            depth = 0;
            fails = 0;
        endfunction

        function longint clamp_coord(longint v);
            if (v > longint'(COORD_MAX)) return longint'(COORD_MAX);
            if (v < longint'(COORD_MIN)) return longint'(COORD_MIN);
            return v;
        endfunction

        function void note_fail(string msg);
            fails++;
            if (fails <= REPORT_MAX) $display("mismatch: %s", msg);
        endfunction

        function void take_vertex(int vx, int vy, bit start);
            longint cx[65];
            longint cy[65];
            longint nx[65];
            longint ny[65];
            longint sx, sy, ex, ey, dx, dy;
            int segs;
            int b;
            t_koch_point p;
            if (start || !have_prev) begin
                // A path start, or a vertex with nothing stored, is echoed.
                prev_x = vx;
                prev_y = vy;
                have_prev = 1'b1;
                p.x = vx;
                p.y = vy;
                p.last = 1'b1;
                points_due = {points_due, p};
                return;
            end
            cx[0] = prev_x;
            cy[0] = prev_y;
            cx[1] = vx;
            cy[1] = vy;
            segs = 1;
            for (int pass = 0; pass < depth; pass++) begin
                nx[0] = cx[0];
                ny[0] = cy[0];
                for (int i = 0; i < segs; i++) begin
                    sx = cx[i];
                    sy = cy[i];
                    ex = cx[i + 1];
                    ey = cy[i + 1];
                    dx = ex - sx;
                    dy = ey - sy;
                    b = 4 * i;
                    // Arithmetic shifts on 64-bit values floor toward minus infinity.
                    nx[b + 1] = clamp_coord(sx + (dx >>> 2));
                    ny[b + 1] = clamp_coord(sy + (dy >>> 2));
                    nx[b + 2] = clamp_coord(sx + (dx >>> 1) + ((ey - sy) >>> 2));
                    ny[b + 2] = clamp_coord(sy + (dy >>> 1) + ((sx - ex) >>> 2));
                    nx[b + 3] = clamp_coord(sx + ((3 * dx) >>> 2));
                    ny[b + 3] = clamp_coord(sy + ((3 * dy) >>> 2));
                    nx[b + 4] = ex;
                    ny[b + 4] = ey;
                end
                segs *= 4;
                cx = nx;
                cy = ny;
            end
            for (int i = 0; i < segs; i++) begin
                p.x = int'(cx[i + 1]);
                p.y = int'(cy[i + 1]);
                p.last = (i == segs - 1);
                points_due = {points_due, p};
            end
            prev_x = vx;
            prev_y = vy;
        endfunction

        function void check_point(logic signed [FIELD_W-1:0] gx, logic signed [FIELD_W-1:0] gy,
                                  logic glast);
            t_koch_point want;
            if (points_due.size() == 0) begin
                note_fail($sformatf("unexpected point (%0d, %0d) last %b", gx, gy, glast));
                return;
            end
            want = points_due.pop_front();
            if (gx !== want.x || gy !== want.y || glast !== want.last)
                note_fail($sformatf("point (%0d, %0d) last %b, expected (%0d, %0d) last %b",
                                    gx, gy, glast, want.x, want.y, want.last));
        endfunction

        function int outstanding();
            return points_due.size();
        endfunction

        function void close();
            if (points_due.size() != 0)
                note_fail($sformatf("%0d points never arrived", points_due.size()));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [DEPTH_W-1:0] cfg_data;
    int send_idle_pct;
    int recv_stall_pct;
    int unsigned cycles = 0;
    koch_tracker tracker;

    ksd_vertex_if vtx ();
    ksd_point_if pts ();

    koch_segment_subdivider u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_vertex   (vtx),
        .o_point    (pts),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Point receiver: checks every transfer and draws a fresh ready each cycle.
    always @(posedge clk) begin
        if (rst_n && pts.valid && pts.ready)
            tracker.check_point(pts.point_x, pts.point_y, pts.last_point);
        pts.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic t_vertex_item mk_vertex(int x, int y, bit start);
        t_vertex_item it;
        it.x = x;
        it.y = y;
        it.start = start;
        return it;
    endfunction

    // Mostly short steps from the previous vertex, with extremes and wild jumps.
    function automatic int pick_coord(int last);
        case ($urandom_range(15))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2, 3: return int'($urandom);
            4, 5: return last + (int'($urandom) >>> 6);
            default: return last + int'($urandom_range(32'h0002_0000)) - 32'sh0001_0000;
        endcase
    endfunction

    task automatic wait_points_done();
        do @(posedge clk); while (tracker.outstanding() != 0);
    endtask

    task automatic write_depth(int unsigned d);
        cfg_we <= 1'b1;
        cfg_data <= d[DEPTH_W-1:0];
        @(posedge clk);
        tracker.depth = d;
        cfg_we <= 1'b0;
    endtask

    // Sends a list of vertices; with hold_mid set, the sender stops halfway
    // until every point owed so far has come out.
    task automatic send_vertices(t_vertex_item items[$], bit hold_mid);
        int gap;
        bit hold;
        for (int i = 0; i < items.size(); i++) begin
            gap = 0;
            while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
            hold = hold_mid && (i == items.size() / 2);
            if (gap > 0 || hold) begin
                vtx.valid <= 1'b0;
                if (hold) wait_points_done();
                repeat (gap) @(posedge clk);
            end
            vtx.valid <= 1'b1;
            vtx.vertex_x <= items[i].x;
            vtx.vertex_y <= items[i].y;
            vtx.start_path <= items[i].start;
            do @(posedge clk); while (vtx.ready !== 1'b1);
            tracker.take_vertex(items[i].x, items[i].y, items[i].start);
        end
        vtx.valid <= 1'b0;
    endtask

    task automatic run_polylines(int count, int unsigned d, int idle, int stall, bit hold_mid);
        t_vertex_item items[$];
        t_vertex_item it;
        int lx;
        int ly;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        write_depth(d);
        lx = tracker.prev_x;
        ly = tracker.prev_y;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 8) begin
                // Repeat the previous vertex to get a zero-length segment.
                it.x = lx;
                it.y = ly;
            end else begin
                it.x = pick_coord(lx);
                it.y = pick_coord(ly);
            end
            it.start = ($urandom_range(99) < 10);
            items = {items, it};
            lx = it.x;
            ly = it.y;
        end
        send_vertices(items, hold_mid);
        wait_points_done();
    endtask

    initial begin
        vtx.valid = 1'b0;
        vtx.vertex_x = '0;
        vtx.vertex_y = '0;
        vtx.start_path = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        tracker = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Depth is zero out of reset; the first vertex has no predecessor.
        send_vertices({mk_vertex(5, 7, 1'b0), mk_vertex(100, -3, 1'b0),
                       mk_vertex(COORD_MIN, COORD_MAX, 1'b0)}, 1'b0);
        wait_points_done();

        // One pass: zero length first, then full-range segments that saturate.
        write_depth(1);
        send_vertices({mk_vertex(COORD_MIN, COORD_MAX, 1'b0),
                       mk_vertex(COORD_MAX, COORD_MAX, 1'b0),
                       mk_vertex(COORD_MIN, COORD_MIN, 1'b0),
                       mk_vertex(COORD_MAX, COORD_MIN, 1'b0),
                       mk_vertex(COORD_MIN, COORD_MAX, 1'b1),
                       mk_vertex(COORD_MAX, COORD_MIN, 1'b0)}, 1'b0);
        wait_points_done();

        write_depth(3);
        send_vertices({mk_vertex(0, 0, 1'b1), mk_vertex(32'sh0001_0000, 0, 1'b0),
                       mk_vertex(-1, -1, 1'b0), mk_vertex(COORD_MIN, COORD_MAX, 1'b0),
                       mk_vertex(COORD_MIN, COORD_MAX, 1'b0),
                       mk_vertex(COORD_MAX, COORD_MIN, 1'b0)}, 1'b0);
        wait_points_done();

        write_depth(2);
        send_vertices({mk_vertex(7, -9, 1'b0), mk_vertex(-3, 5, 1'b1),
                       mk_vertex(COORD_MIN, COORD_MIN, 1'b0),
                       mk_vertex(COORD_MAX, 0, 1'b0)}, 1'b0);
        wait_points_done();

        // Random polylines over every idling mix and depth.
        run_polylines(30, 3, 0, 0, 1'b0);
        run_polylines(30, 0, 0, 0, 1'b0);
        run_polylines(30, 1, 74, 0, 1'b1);
        run_polylines(30, 3, 74, 0, 1'b0);
        run_polylines(30, 2, 0, 74, 1'b0);
        run_polylines(30, 3, 0, 74, 1'b1);
        run_polylines(30, 0, 37, 37, 1'b0);
        run_polylines(30, 3, 37, 37, 1'b0);

        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        tracker.close();
        if (tracker.fails == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/ksd_pkg.sv
rtl/ksd_if.sv
rtl/ksd_ram.sv
rtl/ksd_controller.sv
rtl/ksd_datapath.sv
rtl/koch_segment_subdivider.sv
rtl/ksd_checker.sv
dv/koch_segment_subdivider_tb.sv
